### rtl/rtt_pkg.sv
// shared types, constants and helpers for the rule text tokenizer
`timescale 1ns / 1ps

package rtt_pkg;

    // position counter width and reported field widths
    localparam int POS_W  = 16;
    localparam int TOK_W  = 16;
    localparam int KIND_W = 3;
    localparam int ZONE_W = 4;
    localparam int PEND_W = 3;

    typedef logic [POS_W-1:0] pos_t;
    localparam pos_t POS_MAX = {POS_W{1'b1}};

    // token kinds
    localparam logic [KIND_W-1:0] KIND_END    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WORD   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUOTE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EQUALS = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OTHER  = 3'd5;

    // pending token classes
    localparam logic [PEND_W-1:0] PEND_NONE    = 3'd0;
    localparam logic [PEND_W-1:0] PEND_NUMBER  = 3'd1;
    localparam logic [PEND_W-1:0] PEND_WORD    = 3'd2;
    localparam logic [PEND_W-1:0] PEND_MINUS   = 3'd3;
    localparam logic [PEND_W-1:0] PEND_SLASH   = 3'd4;
    localparam logic [PEND_W-1:0] PEND_BANG    = 3'd5;
    localparam logic [PEND_W-1:0] PEND_LESS    = 3'd6;
    localparam logic [PEND_W-1:0] PEND_GREATER = 3'd7;

    // input op codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // characters that matter
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // one emitted token
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TOK_W-1:0]  start;
        logic [TOK_W-1:0]  length;
        logic [ZONE_W-1:0] zone;
        logic              last;
    } token_t;

    // up to two tokens from one transaction, packed from first
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } token_pair_t;

    // byte classification
    typedef struct packed {
        logic              is_digit;
        logic              is_word;
        logic              is_space;
        logic              is_quote;
        logic              is_equals;
        logic [PEND_W-1:0] lead;
    } byte_class_t;

    // position to reported width, zero extended or truncated
    function automatic logic [TOK_W-1:0] to_tok(input pos_t v);
        logic [POS_W+TOK_W-1:0] ext;
        ext = {{TOK_W{1'b0}}, v};
        return ext[TOK_W-1:0];
    endfunction

endpackage

### rtl/rule_text_tokenizer_unit.sv
// top level of the rule text tokenizer
`timescale 1ns / 1ps

//  channel  | direction | tdata                              | tuser      | tlast
//  s_       | in        | [7:0] data_byte                    | [0] op     | -
//  m_       | out       | [15:0] start [31:16] length        | [2:0] kind | last of byte
//           |           | [35:32] zone [39:36] zero          |            |
//  cfg_     | in        | [3:0] zone_tag                     | -          | -
//
// one byte per cycle: an input register feeds the classifier and the token
// decision, which write up to two tokens into a four-entry output queue.
// a byte is held in the input register; its tokens are then registered in the queue.
// the input register stalls while the queue holds more than two tokens.
// reset clears the valid flag, tokenizer state, queue pointers and the zone tag; no clearing pass is needed.

module rule_text_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] op
    // tokens
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] start, [31:16] length, [35:32] zone
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast,
    // zone tag write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // [3:0] zone_tag
);
    import rtt_pkg::*;

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        room;
    byte_class_t cls;
    token_pair_t tokens;
    token_t      out_tok;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    rtt_classify u_classify (
        .data_byte (in_byte_reg),
        .cls       (cls)
    );

    rtt_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item_op    (in_op_reg),
        .item_byte  (in_byte_reg),
        .cls        (cls),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_zone   (cfg_data),
        .tokens     (tokens)
    );

    rtt_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (tokens),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    // result transaction fields
    assign m_tdata = {4'b0000, out_tok.zone, out_tok.length, out_tok.start};
    assign m_tuser = out_tok.kind;
    assign m_tlast = out_tok.last;

endmodule

### rtl/rtt_classify.sv
// byte classifier: character class and pair lead code
`timescale 1ns / 1ps

module rtt_classify (
    input  logic [7:0]          data_byte,
    output rtt_pkg::byte_class_t cls
);
    import rtt_pkg::*;

    // character ranges
    always_comb begin
        cls.is_digit  = (data_byte >= 8'h30) && (data_byte <= 8'h39);
        cls.is_word   = ((data_byte >= 8'h61) && (data_byte <= 8'h7A))
                     || ((data_byte >= 8'h41) && (data_byte <= 8'h5A))
                     || (data_byte == CH_UNDER);
        cls.is_space  = (data_byte == CH_SPACE) || (data_byte == CH_TAB)
                     || (data_byte == CH_CR) || (data_byte == CH_LF);
        cls.is_quote  = (data_byte == CH_SQUOTE) || (data_byte == CH_DQUOTE);
        cls.is_equals = (data_byte == CH_EQ);
    end

    // possible first byte of a two-byte token
    always_comb begin
        case (data_byte)
            CH_MINUS: cls.lead = PEND_MINUS;
            CH_SLASH: cls.lead = PEND_SLASH;
            CH_BANG:  cls.lead = PEND_BANG;
            CH_LT:    cls.lead = PEND_LESS;
            CH_GT:    cls.lead = PEND_GREATER;
            default:  cls.lead = PEND_NONE;
        endcase
    end

endmodule

### rtl/rtt_core.sv
// tokenizer state and per-byte token decision
`timescale 1ns / 1ps

module rtt_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  logic                          item_op,
    input  logic [7:0]                    item_byte,
    input  rtt_pkg::byte_class_t          cls,
    input  logic                          cfg_we,
    input  logic [rtt_pkg::ZONE_W-1:0]    cfg_zone,
    output rtt_pkg::token_pair_t          tokens
);
    import rtt_pkg::*;

    logic [PEND_W-1:0] pend_reg, pend_next;
    pos_t              pstart_reg, pstart_next;
    pos_t              pos_reg, pos_next;
    logic [ZONE_W-1:0] zone_reg;

    pos_t              diff;
    pos_t              run_len;
    logic              cont;
    logic              pair;
    logic              f_valid, e_valid;
    token_t            f_tok, e_tok;

    // length of the pending number or word, at least one
    assign diff    = pos_reg - pstart_reg;
    assign run_len = (diff == '0) ? pos_t'(1) : diff;

    // does the byte finish a two-byte token
    always_comb begin
        unique case (pend_reg)
            PEND_MINUS:   pair = (item_byte == CH_MINUS);
            PEND_SLASH:   pair = (item_byte == CH_STAR);
            PEND_BANG:    pair = (item_byte == CH_EQ);
            PEND_LESS:    pair = (item_byte == CH_EQ) || (item_byte == CH_GT);
            PEND_GREATER: pair = (item_byte == CH_EQ);
            default:      pair = 1'b0;
        endcase
    end

    assign cont = ((pend_reg == PEND_NUMBER) && cls.is_digit)
               || ((pend_reg == PEND_WORD) && (cls.is_word || cls.is_digit));

    // first token: flush of pending or completed pair; second: own or end token
    always_comb begin
        f_tok        = '0;
        f_tok.zone   = zone_reg;
        f_tok.start  = to_tok(pstart_reg);
        f_valid      = 1'b0;
        e_tok        = '0;
        e_tok.zone   = zone_reg;
        e_tok.start  = to_tok(pos_reg);
        e_tok.length = TOK_W'(1);
        e_valid      = 1'b0;
        pend_next    = pend_reg;
        pstart_next  = pstart_reg;
        pos_next     = (pos_reg != POS_MAX) ? pos_reg + pos_t'(1) : pos_reg;

        // flush token of whatever is pending
        case (pend_reg)
            PEND_NUMBER: begin
                f_tok.kind   = KIND_NUMBER;
                f_tok.length = to_tok(run_len);
            end
            PEND_WORD: begin
                f_tok.kind   = KIND_WORD;
                f_tok.length = to_tok(run_len);
            end
            default: begin
                f_tok.kind   = KIND_OTHER;
                f_tok.length = TOK_W'(1);
            end
        endcase

        if (item_op == OP_END) begin
            f_valid      = (pend_reg != PEND_NONE);
            e_valid      = 1'b1;
            e_tok.kind   = KIND_END;
            e_tok.length = '0;
            pend_next    = PEND_NONE;
            pstart_next  = '0;
            pos_next     = '0;
        end else if (cont) begin
            // run goes on
        end else if (pair) begin
            f_valid      = 1'b1;
            f_tok.kind   = KIND_OTHER;
            f_tok.length = TOK_W'(2);
            pend_next    = PEND_NONE;
        end else begin
            f_valid   = (pend_reg != PEND_NONE);
            pend_next = PEND_NONE;
            if (!cls.is_space) begin
                if (cls.is_digit) begin
                    pend_next   = PEND_NUMBER;
                    pstart_next = pos_reg;
                end else if (cls.is_word) begin
                    pend_next   = PEND_WORD;
                    pstart_next = pos_reg;
                end else if (cls.lead != PEND_NONE) begin
                    pend_next   = cls.lead;
                    pstart_next = pos_reg;
                end else begin
                    pstart_next = pos_reg;
                    e_valid     = 1'b1;
                    if (cls.is_quote) begin
                        e_tok.kind = KIND_QUOTE;
                    end else if (cls.is_equals) begin
                        e_tok.kind = KIND_EQUALS;
                    end else begin
                        e_tok.kind = KIND_OTHER;
                    end
                end
            end
        end
    end

    // pack the tokens and mark the last one
    always_comb begin
        tokens = '0;
        if (item_valid) begin
            if (f_valid && e_valid) begin
                tokens.count       = 2'd2;
                tokens.first       = f_tok;
                tokens.second      = e_tok;
                tokens.second.last = 1'b1;
            end else if (f_valid) begin
                tokens.count      = 2'd1;
                tokens.first      = f_tok;
                tokens.first.last = 1'b1;
            end else if (e_valid) begin
                tokens.count      = 2'd1;
                tokens.first      = e_tok;
                tokens.first.last = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= PEND_NONE;
            pstart_reg <= '0;
            pos_reg    <= '0;
            zone_reg   <= '0;
        end else begin
            if (item_valid) begin
                pend_reg   <= pend_next;
                pstart_reg <= pstart_next;
                pos_reg    <= pos_next;
            end
            if (cfg_we) begin
                zone_reg <= cfg_zone;
            end
        end
    end

endmodule

### rtl/rtt_out_queue.sv
// four-entry result queue, takes up to two tokens a cycle, gives one
`timescale 1ns / 1ps

module rtt_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rtt_pkg::token_pair_t push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rtt_pkg::token_t      out_tok
);
    import rtt_pkg::*;

    token_t     entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign out_tok   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a full pair regardless of this cycle's pop
    assign room      = (count_reg <= 3'd2);

    // payload entries
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push.count;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, push.count} - {2'b00, pop};
        end
    end

endmodule
